FILE: design/gnwg_pkg.sv
`timescale 1ns / 1ps
// gnwg_pkg: shared types and constants of the grid neighbour weight generator
// depends on nothing; imported by every module of the block

package gnwg_pkg;

	// fixed field widths
	localparam int COORD_W   = 12;
	localparam int COLOUR_W  = 8;
	localparam int CELL_W    = 13;
	localparam int CCELL_W   = 9;
	localparam int SCALE_W   = 17;
	localparam int WEIGHT_W  = 17;
	localparam int DIMS      = 6;
	localparam int NCELLS    = 7;
	localparam int CFG_IDX_W = 3;

	// default fraction bits and register reset value
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 17'h10000;

	// scaled point width: widest coordinate times scale
	localparam int SCALED_W = COORD_W + SCALE_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FRAME    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_COLUMN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_ROW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_COLOUR_A = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_COLOUR_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_COLOUR_C = 3'd5;

	typedef struct packed {
		logic [COORD_W-1:0]  frame_number;
		logic [COORD_W-1:0]  pixel_column;
		logic [COORD_W-1:0]  pixel_row;
		logic [COLOUR_W-1:0] colour_a;
		logic [COLOUR_W-1:0] colour_b;
		logic [COLOUR_W-1:0] colour_c;
	} pixel_t;

	typedef struct packed {
		logic [CELL_W-1:0]   cell_frame;
		logic [CELL_W-1:0]   cell_column;
		logic [CELL_W-1:0]   cell_row;
		logic [CCELL_W-1:0]  cell_colour_a;
		logic [CCELL_W-1:0]  cell_colour_b;
		logic [CCELL_W-1:0]  cell_colour_c;
		logic [WEIGHT_W-1:0] cell_weight;
		logic                last_cell;
	} cell_t;

	typedef logic [DIMS-1:0][SCALE_W-1:0] scales_t;

endpackage

FILE: design/gnwg_front.sv
`timescale 1ns / 1ps
// gnwg_front: accepts pixels, scales the six coordinates and classifies them
// into nearest cell, distance and side; depends on gnwg_pkg

module gnwg_front import gnwg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NW        = SCALED_W + 1 - FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pixel_t                        in_data,
	input  scales_t                       scale,
	output logic                          cls_valid,
	input  logic                          cls_stall,
	output logic [DIMS-1:0][NW-1:0]       near,
	output logic [DIMS-1:0][FRAC_BITS-1:0] offs,
	output logic [DIMS-1:0]               up
);

	localparam logic [SCALED_W:0] HALF = (SCALED_W+1)'(1) << (FRAC_BITS - 1);

	logic [DIMS-1:0][COORD_W-1:0]  x;
	logic [DIMS-1:0][SCALED_W-1:0] scaled_s1;
	logic                          valid_s1;
	logic                          valid_s2;
	logic                          adv1;
	logic                          adv2;

	assign x[0] = in_data.frame_number;
	assign x[1] = in_data.pixel_column;
	assign x[2] = in_data.pixel_row;
	assign x[3] = COORD_W'(in_data.colour_a);
	assign x[4] = COORD_W'(in_data.colour_b);
	assign x[5] = COORD_W'(in_data.colour_c);

	// pipeline advance
	assign adv2     = !valid_s2 || !cls_stall;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;
	assign cls_valid = valid_s2;

	// stage 1: one multiplier per coordinate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			for (int d = 0; d < DIMS; d++) begin
				scaled_s1[d] <= x[d] * scale[d];
			end
		end
	end

	// stage 2: round half up, distance and side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [SCALED_W:0] rnd;
		logic [SCALED_W:0] base;
		logic [SCALED_W:0] sx;
		logic [SCALED_W:0] diff;
		if (adv2 && valid_s1) begin
			for (int d = 0; d < DIMS; d++) begin
				sx   = {1'b0, scaled_s1[d]};
				rnd  = sx + HALF;
				base = (rnd >> FRAC_BITS) << FRAC_BITS;
				near[d] <= rnd[SCALED_W:FRAC_BITS];
				if (sx < base) begin
					diff = base - sx;
					up[d] <= 1'b0;
				end else begin
					diff = sx - base;
					up[d] <= 1'b1;
				end
				offs[d] <= diff[FRAC_BITS-1:0];
			end
		end
	end

endmodule

FILE: design/gnwg_queue.sv
`timescale 1ns / 1ps
// gnwg_queue: two-entry queue between the classifying front and the weight back
// depends on gnwg_pkg

module gnwg_queue import gnwg_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_stall,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_pop,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;
	logic             push;

	assign wr_stall = (count_q == 2'd2);
	assign push     = wr_valid && !wr_stall;
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (rd_pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(rd_pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

FILE: design/gnwg_back.sv
`timescale 1ns / 1ps
// gnwg_back: builds the seven cell weights, normalises them and emits the cells
// depends on gnwg_pkg

module gnwg_back import gnwg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NW        = SCALED_W + 1 - FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ent_valid,
	output logic                           ent_pop,
	input  logic [DIMS-1:0][NW-1:0]        ent_near,
	input  logic [DIMS-1:0][FRAC_BITS-1:0] ent_dist,
	input  logic [DIMS-1:0]                ent_up,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cell_t                          out_data
);

	localparam int CNT_W = $clog2(FRAC_BITS + 2);
	localparam int SUM_W = FRAC_BITS + 4;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                     state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [2:0]                     k_q;
	logic [DIMS-1:0][NW-1:0]        near_q;
	logic [DIMS-1:0][FRAC_BITS-1:0] dist_q;
	logic [DIMS-1:0]                up_q;
	logic [NCELLS-1:0][FRAC_BITS:0] w_q;
	logic [NCELLS-1:0][SUM_W-1:0]   rem_q;
	logic [NCELLS-1:0][FRAC_BITS:0] quo_q;
	logic [SUM_W-1:0]               sum_q;
	logic                           emit_done;

	assign ent_pop   = (state_q == ST_IDLE) && ent_valid;
	assign out_valid = (state_q == ST_EMIT);
	assign emit_done = out_valid && !out_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ent_valid) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIMS - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(FRAC_BITS)) begin
						state_q <= ST_EMIT;
						k_q     <= '0;
					end
				end
				ST_EMIT: begin
					if (emit_done) begin
						k_q <= k_q + 1'b1;
						if (k_q == 3'(NCELLS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: seven weight lanes, one factor per cycle, then restoring division
	always_ff @(posedge clk) begin
		logic [FRAC_BITS:0]     f;
		logic [2*FRAC_BITS+1:0] prod;
		logic [SUM_W:0]         r2;
		logic [SUM_W-1:0]       acc;
		if (ent_pop) begin
			near_q <= ent_near;
			dist_q <= ent_dist;
			up_q   <= ent_up;
			for (int k = 0; k < NCELLS; k++) begin
				w_q[k] <= ONE;
			end
		end
		if (state_q == ST_MUL) begin
			for (int k = 0; k < NCELLS; k++) begin
				if (k == int'(cnt_q) + 1) begin
					f = {1'b0, dist_q[cnt_q[2:0]]};
				end else begin
					f = ONE - {1'b0, dist_q[cnt_q[2:0]]};
				end
				prod = w_q[k] * f;
				w_q[k] <= prod[2*FRAC_BITS:FRAC_BITS];
			end
		end
		if (state_q == ST_SUM) begin
			acc = '0;
			for (int k = 0; k < NCELLS; k++) begin
				acc = acc + SUM_W'(w_q[k]);
				rem_q[k] <= SUM_W'(w_q[k] >> 1);
				quo_q[k] <= '0;
			end
			sum_q <= acc;
		end
		if (state_q == ST_DIV) begin
			for (int k = 0; k < NCELLS; k++) begin
				r2 = {rem_q[k], (cnt_q == '0) ? w_q[k][0] : 1'b0};
				if (r2 >= {1'b0, sum_q}) begin
					r2 = r2 - {1'b0, sum_q};
					quo_q[k] <= {quo_q[k][FRAC_BITS-1:0], 1'b1};
				end else begin
					quo_q[k] <= {quo_q[k][FRAC_BITS-1:0], 1'b0};
				end
				rem_q[k] <= r2[SUM_W-1:0];
			end
		end
	end

	// cell coordinates and weight of the cell on show
	always_comb begin
		logic [DIMS-1:0][31:0] c;
		logic [31:0]           q32;
		for (int d = 0; d < DIMS; d++) begin
			c[d] = 32'(near_q[d]);
			if (int'(k_q) == d + 1) begin
				c[d] = up_q[d] ? c[d] + 32'd1 : c[d] - 32'd1;
			end
		end
		q32 = (sum_q == '0) ? 32'd0 : 32'(quo_q[k_q]);
		out_data.cell_frame    = c[0][CELL_W-1:0];
		out_data.cell_column   = c[1][CELL_W-1:0];
		out_data.cell_row      = c[2][CELL_W-1:0];
		out_data.cell_colour_a = c[3][CCELL_W-1:0];
		out_data.cell_colour_b = c[4][CCELL_W-1:0];
		out_data.cell_colour_c = c[5][CCELL_W-1:0];
		out_data.cell_weight   = q32[WEIGHT_W-1:0];
		out_data.last_cell     = (k_q == 3'(NCELLS - 1));
	end

	// the nearest factor is at least one half, so the sum never vanishes
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> sum_q != '0)
		else $error("weight sum is zero during division");

	// a normalised weight never exceeds one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quo_q[k_q] <= ONE)
		else $error("normalised weight above one");

	// the last cell transfer returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_done && out_data.last_cell |=> state_q == ST_IDLE)
		else $error("sequencer not idle after last cell");

	// a new entry is only taken when the previous pixel is finished
	assert property (@(posedge clk) disable iff (!arst_n)
		ent_pop |=> state_q == ST_MUL && cnt_q == '0)
		else $error("entry taken outside idle");

endmodule

FILE: design/grid_neighbour_weight_generator_unit.sv
`timescale 1ns / 1ps
// grid_neighbour_weight_generator_unit: top level of the grid neighbour weight generator
// path: the front's multiply and round stages, the two-entry queue, then the back sequencer
// the back takes a new pixel only after emitting all cells of the last one, so it sets the pixel rate
// back sequencer: entry take, a factor step per dimension, sum, one division step per quotient bit, seven cells
// the front keeps accepting into a two-entry queue while the back works, until the queue fills
// reset: asynchronous, active low; scales reset to 65536, pipeline and queue empty

module grid_neighbour_weight_generator_unit import gnwg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pixel_t               in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cell_t                out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data
);

	localparam int NW    = SCALED_W + 1 - FRAC_BITS;
	localparam int ENT_W = DIMS * NW + DIMS * FRAC_BITS + DIMS;

	scales_t                        scale_q;
	logic                           cls_valid;
	logic                           cls_stall;
	logic [DIMS-1:0][NW-1:0]        near;
	logic [DIMS-1:0][FRAC_BITS-1:0] offs;
	logic [DIMS-1:0]                up;
	logic                           q_valid;
	logic                           q_pop;
	logic [ENT_W-1:0]               q_data;
	logic [DIMS-1:0][NW-1:0]        q_near;
	logic [DIMS-1:0][FRAC_BITS-1:0] q_dist;
	logic [DIMS-1:0]                q_up;

	// scale registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIMS; d++) begin
				scale_q[d] <= SCALE_RESET;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE_FRAME:    scale_q[0] <= cfg_data;
				CFG_SCALE_COLUMN:   scale_q[1] <= cfg_data;
				CFG_SCALE_ROW:      scale_q[2] <= cfg_data;
				CFG_SCALE_COLOUR_A: scale_q[3] <= cfg_data;
				CFG_SCALE_COLOUR_B: scale_q[4] <= cfg_data;
				CFG_SCALE_COLOUR_C: scale_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	gnwg_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.scale     (scale_q),
		.cls_valid (cls_valid),
		.cls_stall (cls_stall),
		.near      (near),
		.offs      (offs),
		.up        (up)
	);

	gnwg_queue #(.WIDTH(ENT_W)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cls_valid),
		.wr_stall (cls_stall),
		.wr_data  ({near, offs, up}),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (q_data)
	);

	assign {q_near, q_dist, q_up} = q_data;

	gnwg_back #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (q_valid),
		.ent_pop   (q_pop),
		.ent_near  (q_near),
		.ent_dist  (q_dist),
		.ent_up    (q_up),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: sim/gnwg_checker.sv
`timescale 1ns / 1ps
// gnwg_checker: predicts the seven weighted grid cells of each pixel and compares them
// depends on gnwg_pkg; watches the pixel and cell channels of the generator

module gnwg_checker import gnwg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  pixel_t               in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  cell_t                out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data,
	output int                   fail_count,
	output int                   cells_pending
);

	logic [SCALE_W-1:0] scale [DIMS];
	cell_t              cell_queue [$];

	// compute the seven cells of one pixel and queue them
	task automatic predict_cells(input pixel_t px);
		logic [63:0] coord [DIMS];
		logic [63:0] nearest [DIMS];
		logic [63:0] offs [DIMS];
		bit          up [DIMS];
		logic [63:0] weight [NCELLS];
		logic [63:0] sum, s, n, base, w, f, c, one;
		cell_t       pred;
		logic [CELL_W-1:0] cw [DIMS];
		one = 64'd1 << FRAC_BITS;
		coord[0] = 64'(px.frame_number);
		coord[1] = 64'(px.pixel_column);
		coord[2] = 64'(px.pixel_row);
		coord[3] = 64'(px.colour_a);
		coord[4] = 64'(px.colour_b);
		coord[5] = 64'(px.colour_c);
		for (int d = 0; d < DIMS; d++) begin
			s = coord[d] * scale[d];
			n = (s + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			base = n << FRAC_BITS;
			nearest[d] = n;
			if (s < base) begin
				offs[d] = base - s;
				up[d] = 0;
			end else begin
				offs[d] = s - base;
				up[d] = 1;
			end
		end
		sum = 0;
		for (int k = 0; k < NCELLS; k++) begin
			w = one;
			for (int d = 0; d < DIMS; d++) begin
				f = (k == d + 1) ? offs[d] : one - offs[d];
				w = (w * f) >> FRAC_BITS;
			end
			weight[k] = w;
			sum += w;
		end
		for (int k = 0; k < NCELLS; k++) begin
			for (int d = 0; d < DIMS; d++) begin
				c = nearest[d];
				if (k == d + 1)
					c = up[d] ? c + 1 : c - 1;
				cw[d] = c[CELL_W-1:0];
			end
			pred.cell_frame    = cw[0];
			pred.cell_column   = cw[1];
			pred.cell_row      = cw[2];
			pred.cell_colour_a = cw[3][CCELL_W-1:0];
			pred.cell_colour_b = cw[4][CCELL_W-1:0];
			pred.cell_colour_c = cw[5][CCELL_W-1:0];
			pred.cell_weight   = (sum != 0) ? WEIGHT_W'((weight[k] << FRAC_BITS) / sum)
				: '0;
			pred.last_cell     = (k == NCELLS - 1);
			cell_queue = {cell_queue, pred};
		end
	endtask

	// report one mismatch, detail only for the first ten
	function automatic void flag_mismatch(input string what, input cell_t exp_c,
		input cell_t act_c);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %s: expected %p actual %p", what, exp_c, act_c);
	endfunction

	// register shadow, prediction and comparison
	always @(posedge clk or negedge arst_n) begin
		cell_t exp_c;
		if (!arst_n) begin
			for (int d = 0; d < DIMS; d++)
				scale[d] <= SCALE_RESET;
			cell_queue.delete();
			fail_count = 0;
			cells_pending = 0;
		end else begin
			if (cfg_we && cfg_index < DIMS)
				scale[cfg_index] <= cfg_data;
			if (in_valid && !in_stall)
				predict_cells(in_data);
			if (out_valid && !out_stall) begin
				if (cell_queue.size() == 0) begin
					flag_mismatch("unexpected cell", '0, out_data);
				end else begin
					exp_c = cell_queue.pop_front();
					if (exp_c.cell_frame !== out_data.cell_frame ||
						exp_c.cell_column !== out_data.cell_column ||
						exp_c.cell_row !== out_data.cell_row ||
						exp_c.cell_colour_a !== out_data.cell_colour_a ||
						exp_c.cell_colour_b !== out_data.cell_colour_b ||
						exp_c.cell_colour_c !== out_data.cell_colour_c ||
						exp_c.cell_weight !== out_data.cell_weight ||
						exp_c.last_cell !== out_data.last_cell)
						flag_mismatch("cell", exp_c, out_data);
				end
			end
			cells_pending = cell_queue.size();
		end
	end

endmodule

FILE: sim/tb_grid_neighbour_weight_generator_unit.sv
`timescale 1ns / 1ps
// tb_grid_neighbour_weight_generator_unit: stimulus and verdict for the weight generator
// depends on gnwg_pkg, the generator top level and gnwg_checker

module tb_grid_neighbour_weight_generator_unit;
	import gnwg_pkg::*;

	localparam int LATENCY = 80;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	pixel_t               in_data;
	logic                 out_valid;
	logic                 out_stall;
	cell_t                out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCALE_W-1:0]   cfg_data;
	int                   fail_count;
	int                   cells_pending;
	bit                   sink_calm;
	bit                   sink_hold;
	int                   idle_cycles;

	grid_neighbour_weight_generator_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gnwg_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .cells_pending(cells_pending)
	);

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// receiver stall: random, with a calm stretch and one long hold-off
	always @(negedge clk) begin
		if (sink_hold)
			out_stall <= 1;
		else if (sink_calm)
			out_stall <= 0;
		else
			out_stall <= ($urandom_range(99) < 21);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// offer one pixel and wait for its transfer, with random gaps before it when gaps is set
	task automatic send_pixel(input pixel_t px, input bit gaps);
		while (gaps && $urandom_range(99) < 21) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_scale(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	// wait until every predicted cell has arrived, then let the pipe settle
	task automatic drain;
		in_valid <= 0;
		@(negedge clk);
		while (cells_pending != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.frame_number = COORD_W'($urandom);
		px.pixel_column = COORD_W'($urandom);
		px.pixel_row = COORD_W'($urandom);
		px.colour_a = COLOUR_W'($urandom);
		px.colour_b = COLOUR_W'($urandom);
		px.colour_c = COLOUR_W'($urandom);
		return px;
	endfunction

	function automatic logic [SCALE_W-1:0] random_scale();
		case ($urandom_range(5))
			0: return 17'd0;
			1: return SCALE_RESET;
			2: return 17'h1FFFF;
			3: return 17'h08000;
			default: return SCALE_W'($urandom_range(65536));
		endcase
	endfunction

	initial begin
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = CFG_SCALE_FRAME;
		cfg_data = '0;
		arst_n = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: field extremes at reset scales
		send_pixel('0, 0);
		send_pixel('1, 0);
		send_pixel('{12'd4095, 12'd0, 12'd4095, 8'd0, 8'd255, 8'd0}, 0);
		send_pixel('{12'd0, 12'd4095, 12'd0, 8'd255, 8'd0, 8'd255}, 0);
		drain();
		// half scale: points on exact halves round up, odd coords sit between cells
		write_scale(CFG_SCALE_FRAME, 17'h08000);
		write_scale(CFG_SCALE_COLUMN, 17'h08000);
		write_scale(CFG_SCALE_ROW, 17'h08000);
		write_scale(CFG_SCALE_COLOUR_A, 17'h08000);
		write_scale(CFG_SCALE_COLOUR_B, 17'h08000);
		write_scale(CFG_SCALE_COLOUR_C, 17'h08000);
		send_pixel('{12'd1, 12'd3, 12'd4095, 8'd1, 8'd255, 8'd7}, 0);
		send_pixel('{12'd2, 12'd4, 12'd0, 8'd0, 8'd2, 8'd128}, 0);
		send_pixel('1, 0);
		drain();
		// awkward scales: zero, max register value (wrap), fractions below and above half
		write_scale(CFG_SCALE_FRAME, 17'd0);
		write_scale(CFG_SCALE_COLUMN, 17'h1FFFF);
		write_scale(CFG_SCALE_ROW, 17'd21845);
		write_scale(CFG_SCALE_COLOUR_A, 17'd43690);
		write_scale(CFG_SCALE_COLOUR_B, 17'd1);
		write_scale(CFG_SCALE_COLOUR_C, 17'd65535);
		send_pixel('1, 0);
		send_pixel('0, 0);
		for (int i = 0; i < 8; i++)
			send_pixel(random_pixel(), 0);
		drain();

		// random phases with varied scales
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < DIMS; r++)
				write_scale(CFG_IDX_W'(r), random_scale());
			sink_calm = (ph == 2);
			for (int i = 0; i < 50; i++) begin
				// long receiver hold-off while pixels keep coming
				if (ph == 4 && i == 5)
					fork
						begin
							sink_hold = 1;
							repeat (400) @(negedge clk);
							sink_hold = 0;
						end
					join_none
				// sender pause until all cells are back
				if (ph == 5 && i == 25) begin
					in_valid <= 0;
					@(negedge clk);
					while (cells_pending != 0)
						@(negedge clk);
				end
				send_pixel(random_pixel(), ph != 2);
			end
			drain();
		end
		sink_calm = 0;

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
design/gnwg_pkg.sv
design/gnwg_front.sv
design/gnwg_queue.sv
design/gnwg_back.sv
design/grid_neighbour_weight_generator_unit.sv
sim/gnwg_checker.sv
sim/tb_grid_neighbour_weight_generator_unit.sv
